@@ src/assert_macros.svh @@
// Assertion macros used by the ray set-up top level.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define RCD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define RCD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ src/rcd_pkg.sv @@
// Package for the raycast column set-up block: widths, register indexes,
// pipeline depths and the structs passed between stages. No dependencies.
package rcd_pkg;

    localparam int ScreenColumnsDefault = 640;
    localparam int DivBitsPerStage      = 4;
    localparam int DivStages            = 32 / DivBitsPerStage;
    localparam int RayStages            = 4;
    localparam int SideStages           = 2;
    localparam int TotalStages          = RayStages + DivStages + SideStages;
    localparam int TdataWidth           = 208;

    typedef enum logic [2:0] {
        REG_POS_X      = 3'd0,
        REG_POS_Y      = 3'd1,
        REG_VIEW_DIR_X = 3'd2,
        REG_VIEW_DIR_Y = 3'd3,
        REG_PLANE_X    = 3'd4,
        REG_PLANE_Y    = 3'd5
    } rcd_reg_t;

    // Partial state of the reciprocal 2^32 / mag.
    typedef struct packed {
        logic [18:0] rem;
        logic [31:0] quot;
        logic [18:0] mag;
    } rcd_div_t;

    // Per-ray values that travel alongside the divider.
    typedef struct packed {
        logic signed [16:0] cam;
        logic signed [18:0] rx;
        logic signed [18:0] ry;
        logic               negx;
        logic               posy;
        logic               infx;
        logic               infy;
        logic               onex;
        logic               oney;
    } rcd_meta_t;

endpackage

@@ src/rcd_ray.sv @@
// Front end of the ray set-up: camera offset, ray direction and magnitudes.
// Four register stages. Depends on rcd_pkg.
module rcd_ray #(
    parameter int SCREEN_COLUMNS = rcd_pkg::ScreenColumnsDefault
) (
    input  logic                clk,
    input  logic                en,
    input  logic [9:0]          column,
    input  logic signed [17:0]  view_dir_x,
    input  logic signed [17:0]  view_dir_y,
    input  logic signed [17:0]  plane_x,
    input  logic signed [17:0]  plane_y,
    output rcd_pkg::rcd_meta_t  meta,
    output logic [18:0]         mag_x,
    output logic [18:0]         mag_y
);
    import rcd_pkg::*;

    // Exact division of column * 2^17 by the column count: multiply by the
    // rounded-up reciprocal and shift, valid for dividends below 2^27.
    localparam int RecipShift = 27 + $clog2(SCREEN_COLUMNS);
    localparam logic [63:0] RecipWide =
        ((64'd1 << RecipShift) + 64'(SCREEN_COLUMNS) - 64'd1) / 64'(SCREEN_COLUMNS);
    localparam logic [27:0] CamRecip = RecipWide[27:0];
    localparam int ProdShift = RecipShift - 17;

    logic [37:0]        prod_reg;
    logic signed [16:0] cam_reg, cam3_reg;
    logic signed [34:0] px_reg, py_reg;
    rcd_meta_t          meta_reg;
    logic [18:0]        mag_x_reg, mag_y_reg;

    logic [37:0]        quot_wide;
    logic signed [28:0] cam_diff;
    logic signed [16:0] cam_next;
    logic signed [19:0] sum_x, sum_y;
    logic signed [18:0] rx_next, ry_next;

    always_comb
    begin
        quot_wide = prod_reg >> ProdShift;
        cam_diff  = $signed({1'b0, quot_wide[27:0]}) - 29'sd65536;
        if (cam_diff > 29'sd65535)
            cam_next = 17'sd65535;
        else
            cam_next = cam_diff[16:0];

        sum_x = {{2{view_dir_x[17]}}, view_dir_x} + {px_reg[34], px_reg[34:16]};
        sum_y = {{2{view_dir_y[17]}}, view_dir_y} + {py_reg[34], py_reg[34:16]};
        if (sum_x[19] != sum_x[18])
            rx_next = sum_x[19] ? 19'sh40000 : 19'sd262143;
        else
            rx_next = sum_x[18:0];
        if (sum_y[19] != sum_y[18])
            ry_next = sum_y[19] ? 19'sh40000 : 19'sd262143;
        else
            ry_next = sum_y[18:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= 38'(column) * 38'(CamRecip);
            cam_reg   <= cam_next;
            px_reg    <= 35'(plane_x) * 35'(cam_reg);
            py_reg    <= 35'(plane_y) * 35'(cam_reg);
            cam3_reg  <= cam_reg;
            meta_reg.cam  <= cam3_reg;
            meta_reg.rx   <= rx_next;
            meta_reg.ry   <= ry_next;
            meta_reg.negx <= rx_next[18];
            meta_reg.posy <= !ry_next[18] && (ry_next != 19'sd0);
            meta_reg.infx <= rx_next == 19'sd0;
            meta_reg.infy <= ry_next == 19'sd0;
            meta_reg.onex <= rx_next == 19'sd1 || rx_next == -19'sd1;
            meta_reg.oney <= ry_next == 19'sd1 || ry_next == -19'sd1;
            mag_x_reg <= rx_next[18] ? 19'(-rx_next) : 19'(rx_next);
            mag_y_reg <= ry_next[18] ? 19'(-ry_next) : 19'(ry_next);
        end
    end

    assign meta  = meta_reg;
    assign mag_x = mag_x_reg;
    assign mag_y = mag_y_reg;

endmodule

@@ src/rcd_div_stage.sv @@
// One registered stage of the restoring reciprocal divider.
// Retires DivBitsPerStage quotient bits. Depends on rcd_pkg.
module rcd_div_stage (
    input  logic               clk,
    input  logic               en,
    input  rcd_pkg::rcd_div_t  d_in,
    output rcd_pkg::rcd_div_t  d_out
);
    import rcd_pkg::*;

    rcd_div_t d_reg, d_next;

    always_comb
    begin
        logic [19:0] r2;
        d_next = d_in;
        for (int i = 0; i < DivBitsPerStage; i++)
        begin
            r2 = {d_next.rem, 1'b0};
            if (r2 >= {1'b0, d_next.mag})
            begin
                r2 = r2 - {1'b0, d_next.mag};
                d_next.quot = {d_next.quot[30:0], 1'b1};
            end
            else
            begin
                d_next.quot = {d_next.quot[30:0], 1'b0};
            end
            d_next.rem = r2[18:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign d_out = d_reg;

endmodule

@@ src/rcd_side.sv @@
// Delta saturation and initial side distance for one axis, two stages.
// Depends on rcd_pkg.
module rcd_side (
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] frac,
    input  logic        toward_low,
    input  logic        inf,
    input  logic        unit,
    input  logic [31:0] quot,
    output logic [31:0] delta,
    output logic [31:0] side
);
    import rcd_pkg::*;

    logic [31:0] delta1_reg, delta2_reg, side_reg, delta_next;
    logic [48:0] prod_reg;
    logic        inf_reg;
    logic [16:0] span;
    logic [32:0] scaled;

    always_comb
    begin
        delta_next = (inf || unit) ? 32'hFFFF_FFFF : quot;
        span = toward_low ? {1'b0, frac} : 17'd65536 - {1'b0, frac};
        scaled = prod_reg[48:16];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            delta1_reg <= delta_next;
            prod_reg   <= 49'(span) * 49'(delta_next);
            inf_reg    <= inf;
            delta2_reg <= delta1_reg;
            side_reg   <= (inf_reg || scaled[32]) ? 32'hFFFF_FFFF : scaled[31:0];
        end
    end

    assign delta = delta2_reg;
    assign side  = side_reg;

endmodule

@@ src/raycast_column_dda_setup.sv @@
// Ray set-up for a grid DDA raycaster. Each input beat carries a screen column
// index; each output beat carries camera offset, ray direction, player map cell,
// delta distances, step signs and initial side distances for that column. One
// column is accepted every cycle while the output beat is not stalled; each
// passes the camera offset and ray direction stages, the reciprocal divider
// (four quotient bits per stage) and the side distance multiply. Whenever the
// output beat is stalled the whole pipeline holds. Configuration writes must
// go in while the pipeline is empty; the block does not enforce this. Depends
// on rcd_pkg, rcd_ray, rcd_div_stage, rcd_side and assert_macros.svh.
`include "assert_macros.svh"

module raycast_column_dda_setup #(
    parameter int SCREEN_COLUMNS = rcd_pkg::ScreenColumnsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    // Column beats.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [9:0] column
    // Result beats.
    output logic        m_tvalid,
    input  logic        m_tready,
    // From bit 0: cam_offset 17, ray_dir_x 19, ray_dir_y 19, cell_x 8, cell_y 8,
    // delta_x 32, delta_y 32, step_sign_x 2, step_sign_y 2, side_x 32,
    // side_y 32, zero fill 5.
    output logic [rcd_pkg::TdataWidth-1:0] m_tdata,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import rcd_pkg::*;

    logic [23:0]        pos_x_reg, pos_y_reg;
    logic signed [17:0] view_dir_x_reg, view_dir_y_reg, plane_x_reg, plane_y_reg;
    logic [TotalStages-1:0] vld_reg;
    logic               en;

    rcd_meta_t          meta_ray;
    rcd_meta_t          meta_pipe_reg [DivStages+SideStages];
    logic [18:0]        mag_x, mag_y;
    rcd_div_t           div_x [DivStages+1];
    rcd_div_t           div_y [DivStages+1];
    logic [31:0]        delta_x, delta_y, side_x, side_y;
    rcd_meta_t          meta_out;

    // The pipeline moves whenever the last stage is empty or being taken.
    assign en        = !vld_reg[TotalStages-1] || m_tready;
    assign s_tready  = en;
    assign m_tvalid  = vld_reg[TotalStages-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg      <= 24'd163840;
            pos_y_reg      <= 24'd163840;
            view_dir_x_reg <= 18'sd65536;
            view_dir_y_reg <= 18'sd0;
            plane_x_reg    <= 18'sd0;
            plane_y_reg    <= 18'sd43254;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_POS_X:      pos_x_reg      <= cfg_data;
                REG_POS_Y:      pos_y_reg      <= cfg_data;
                REG_VIEW_DIR_X: view_dir_x_reg <= cfg_data[17:0];
                REG_VIEW_DIR_Y: view_dir_y_reg <= cfg_data[17:0];
                REG_PLANE_X:    plane_x_reg    <= cfg_data[17:0];
                REG_PLANE_Y:    plane_y_reg    <= cfg_data[17:0];
                default:        ;
            endcase
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[TotalStages-2:0], s_tvalid};
    end

    rcd_ray #(
        .SCREEN_COLUMNS(SCREEN_COLUMNS)
    ) u_ray (
        .clk        (clk),
        .en         (en),
        .column     (s_tdata[9:0]),
        .view_dir_x (view_dir_x_reg),
        .view_dir_y (view_dir_y_reg),
        .plane_x    (plane_x_reg),
        .plane_y    (plane_y_reg),
        .meta       (meta_ray),
        .mag_x      (mag_x),
        .mag_y      (mag_y)
    );

    // The dividend 2^32 starts as a remainder of one with 32 zero bits to go.
    assign div_x[0] = '{rem: 19'd1, quot: 32'd0, mag: mag_x};
    assign div_y[0] = '{rem: 19'd1, quot: 32'd0, mag: mag_y};

    for (genvar k = 0; k < DivStages; k++)
    begin : g_div
        rcd_div_stage u_div_x (
            .clk   (clk),
            .en    (en),
            .d_in  (div_x[k]),
            .d_out (div_x[k+1])
        );
        rcd_div_stage u_div_y (
            .clk   (clk),
            .en    (en),
            .d_in  (div_y[k]),
            .d_out (div_y[k+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_pipe_reg[0] <= meta_ray;
            for (int k = 1; k < DivStages + SideStages; k++)
                meta_pipe_reg[k] <= meta_pipe_reg[k-1];
        end
    end

    rcd_side u_side_x (
        .clk        (clk),
        .en         (en),
        .frac       (pos_x_reg[15:0]),
        .toward_low (meta_pipe_reg[DivStages-1].negx),
        .inf        (meta_pipe_reg[DivStages-1].infx),
        .unit       (meta_pipe_reg[DivStages-1].onex),
        .quot       (div_x[DivStages].quot),
        .delta      (delta_x),
        .side       (side_x)
    );

    rcd_side u_side_y (
        .clk        (clk),
        .en         (en),
        .frac       (pos_y_reg[15:0]),
        .toward_low (meta_pipe_reg[DivStages-1].posy),
        .inf        (meta_pipe_reg[DivStages-1].infy),
        .unit       (meta_pipe_reg[DivStages-1].oney),
        .quot       (div_y[DivStages].quot),
        .delta      (delta_y),
        .side       (side_y)
    );

    assign meta_out = meta_pipe_reg[DivStages+SideStages-1];

    assign m_tdata = {5'd0, side_y, side_x,
                      (meta_out.posy ? 2'b11 : 2'b01),
                      (meta_out.negx ? 2'b11 : 2'b01),
                      delta_y, delta_x,
                      pos_y_reg[23:16], pos_x_reg[23:16],
                      meta_out.ry, meta_out.rx, meta_out.cam};

    `RCD_ASSERT_IMPLY(a_inf_x, m_tvalid && meta_out.rx == 19'sd0,
        delta_x == 32'hFFFF_FFFF && side_x == 32'hFFFF_FFFF, "x zero ray not saturated")
    `RCD_ASSERT_IMPLY(a_inf_y, m_tvalid && meta_out.ry == 19'sd0,
        delta_y == 32'hFFFF_FFFF && side_y == 32'hFFFF_FFFF, "y zero ray not saturated")
    `RCD_ASSERT_ALWAYS(a_ready_when_empty, m_tvalid || s_tready, "input blocked while empty")

endmodule

@@ bench/raycast_column_dda_setup_checker.sv @@
// Checker for the raycast column set-up block: watches the column, result and
// configuration channels, predicts each result and compares it field by field.
// Depends on rcd_pkg for the register index codes.
module raycast_column_dda_setup_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [15:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [207:0] m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_data,
    output int           fail_count,
    output int           pending,
    output int           rays_checked,
    output int           inf_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import rcd_pkg::*;

    localparam int Columns = 640;

    typedef struct packed {
        logic [31:0] side_y;
        logic [31:0] side_x;
        logic [1:0]  step_y;
        logic [1:0]  step_x;
        logic [31:0] delta_y;
        logic [31:0] delta_x;
        logic [7:0]  cell_y;
        logic [7:0]  cell_x;
        logic [18:0] ray_y;
        logic [18:0] ray_x;
        logic [16:0] cam;
    } ray_setup_t;

    logic [23:0]        pos_x, pos_y;
    logic signed [17:0] view_x, view_y, plane_x, plane_y;
    ray_setup_t         expected_rays[$];

    function automatic longint floor_q16(longint v);
        if (v >= 0)
            return v / 65536;
        return -((-v + 65535) / 65536);
    endfunction

    function automatic longint ray_axis(longint dir, longint pl, longint cam);
        longint r;
        r = dir + floor_q16(pl * cam);
        if (r > 262143)
            r = 262143;
        if (r < -262144)
            r = -262144;
        return r;
    endfunction

    function automatic logic [31:0] recip(longint r);
        longint unsigned mag, q;
        if (r == 0)
            return 32'hFFFF_FFFF;
        mag = (r < 0) ? -r : r;
        q = (64'd1 << 32) / mag;
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic logic [31:0] side_dist(bit low, logic [23:0] pos, longint r,
                                             logic [31:0] d);
        longint unsigned span, p;
        if (r == 0)
            return 32'hFFFF_FFFF;
        span = low ? pos[15:0] : 65536 - pos[15:0];
        p = (span * d) >> 16;
        return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    function automatic ray_setup_t predict_ray(logic [9:0] col);
        ray_setup_t o;
        longint cam, rx, ry;
        cam = (longint'(col) * 2 * 65536) / Columns - 65536;
        if (cam > 65535)
            cam = 65535;
        rx = ray_axis(view_x, plane_x, cam);
        ry = ray_axis(view_y, plane_y, cam);
        o.cam = cam[16:0];
        o.ray_x = rx[18:0];
        o.ray_y = ry[18:0];
        o.cell_x = pos_x[23:16];
        o.cell_y = pos_y[23:16];
        o.delta_x = recip(rx);
        o.delta_y = recip(ry);
        o.step_x = (rx < 0) ? 2'b11 : 2'b01;
        o.step_y = (ry > 0) ? 2'b11 : 2'b01;
        o.side_x = side_dist(rx < 0, pos_x, rx, o.delta_x);
        o.side_y = side_dist(ry > 0, pos_y, ry, o.delta_y);
        return o;
    endfunction

    // One macro-free comparison per field keeps the error text specific.
    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s expected %h actual %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ray_setup_t e, a;
        if (!rst_n)
        begin
            pos_x <= 24'd163840;
            pos_y <= 24'd163840;
            view_x <= 18'sd65536;
            view_y <= 18'sd0;
            plane_x <= 18'sd0;
            plane_y <= 18'sd43254;
            expected_rays.delete();
            fail_count = 0;
            pending = 0;
            rays_checked = 0;
            inf_seen = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                a = m_tdata[202:0];
                if (expected_rays.size() == 0)
                begin
                    $error("result beat with no column outstanding");
                    fail_count++;
                end
                else
                begin
                    e = expected_rays.pop_front();
                    compare_field("cam_offset", e.cam, a.cam);
                    compare_field("ray_dir_x", e.ray_x, a.ray_x);
                    compare_field("ray_dir_y", e.ray_y, a.ray_y);
                    compare_field("cell_x", e.cell_x, a.cell_x);
                    compare_field("cell_y", e.cell_y, a.cell_y);
                    compare_field("delta_x", e.delta_x, a.delta_x);
                    compare_field("delta_y", e.delta_y, a.delta_y);
                    compare_field("step_sign_x", e.step_x, a.step_x);
                    compare_field("step_sign_y", e.step_y, a.step_y);
                    compare_field("side_x", e.side_x, a.side_x);
                    compare_field("side_y", e.side_y, a.side_y);
                    compare_field("zero_fill", 0, m_tdata[207:203]);
                    rays_checked++;
                    if (e.delta_x == 32'hFFFF_FFFF || e.delta_y == 32'hFFFF_FFFF)
                        inf_seen++;
                end
            end
            if (s_tvalid && s_tready)
                expected_rays.push_back(predict_ray(s_tdata[9:0]));
            pending = expected_rays.size();
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_POS_X:      pos_x <= cfg_data;
                    REG_POS_Y:      pos_y <= cfg_data;
                    REG_VIEW_DIR_X: view_x <= cfg_data[17:0];
                    REG_VIEW_DIR_Y: view_y <= cfg_data[17:0];
                    REG_PLANE_X:    plane_x <= cfg_data[17:0];
                    REG_PLANE_Y:    plane_y <= cfg_data[17:0];
                    default:        ;
                endcase
            end
        end
    end
endmodule

@@ bench/raycast_column_dda_setup_test.sv @@
// Top of the raycast column set-up bench: clock, reset, column and register
// stimulus, random back-pressure and the verdict. Needs the block, rcd_pkg
// and raycast_column_dda_setup_checker.
module raycast_column_dda_setup_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rcd_pkg::*;

    // The pipeline is 14 stages deep; waiting a bit beyond that drains it.
    localparam int DrainCycles = 40;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [15:0]  s_tdata = '0;    // [9:0] column, zero fill above
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // From bit 0: cam_offset 17, ray_dir_x 19, ray_dir_y 19, cell_x 8, cell_y 8,
    // delta_x 32, delta_y 32, step_sign_x 2, step_sign_y 2, side_x 32,
    // side_y 32, zero fill 5.
    logic [207:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [23:0]  cfg_data = '0;

    int  fail_count, pending, rays_checked, inf_seen;
    int  columns_sent = 0;
    int  phases_run = 0;
    bit  hold_off = 1'b0;

    always #6 clk = ~clk;

    raycast_column_dda_setup u_dut (
        .clk, .rst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
        .m_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    raycast_column_dda_setup_checker u_check (
        .clk, .rst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
        .m_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .fail_count, .pending, .rays_checked, .inf_seen
    );

    // Receiver: a random stall before each beat, plus one long hold-off
    // requested by the stimulus so the pipeline fills and blocks its input.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (gap != 0 || hold_off)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
                while (hold_off)
                    @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    task automatic write_reg(rcd_reg_t idx, logic [23:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Sender: one column beat after a random gap, none when no_gap is set.
    // The valid stays up between beats with no gap; wait_idle drops it.
    task automatic send_column(logic [9:0] col, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata <= {6'd0, col};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        columns_sent++;
    endtask

    // Registers only change once every outstanding ray has come back and the
    // pipeline has had time to go empty.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // A direction or plane component: often an extreme, zero or +/-1.0, else
    // random, so the infinite-delta and |r| = 1 cases come up.
    function automatic logic [23:0] pick_dir();
        case ($urandom_range(0, 7))
            0: return 24'(18'sh20000);
            1: return 24'(18'sh1FFFF);
            2: return 24'd0;
            3: return 24'd65536;
            4: return 24'(-18'sd65536);
            default: return 24'($urandom_range(0, 18'h3FFFF));
        endcase
    endfunction

    function automatic logic [23:0] pick_pos();
        case ($urandom_range(0, 5))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return {8'($urandom_range(0, 255)), 16'h0000};
            default: return 24'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    initial
    begin
        logic [9:0] col;
        rcd_reg_t   idx;
        logic [9:0] directed_cols [10];
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset registers, screen edges, the center, columns past
        // the screen width (cam_offset saturates) and the all-ones column.
        directed_cols = '{10'd0, 10'd1, 10'd319, 10'd320, 10'd321, 10'd638,
                          10'd639, 10'd640, 10'd700, 10'd1023};
        foreach (directed_cols[i])
            send_column(directed_cols[i], 1'b0);
        wait_idle();

        // Directed: axis-aligned view so one ray component is zero at the
        // center column, |r| = 1 makes the reciprocal overflow, and extreme
        // positions stress the side products.
        write_reg(REG_POS_X, 24'hFFFFFF);
        write_reg(REG_POS_Y, 24'd0);
        write_reg(REG_VIEW_DIR_X, 24'd0);
        write_reg(REG_VIEW_DIR_Y, 24'(-18'sd65536));
        write_reg(REG_PLANE_X, 24'(18'sh1FFFF));
        write_reg(REG_PLANE_Y, 24'(18'sh20000));
        send_column(10'd320, 1'b0);
        send_column(10'd0, 1'b0);
        send_column(10'd639, 1'b0);
        send_column(10'd1023, 1'b0);
        send_column(10'd160, 1'b0);
        wait_idle();
        write_reg(REG_VIEW_DIR_X, 24'(18'sh20000));
        write_reg(REG_VIEW_DIR_Y, 24'(18'sh1FFFF));
        write_reg(REG_PLANE_X, 24'd0);
        write_reg(REG_PLANE_Y, 24'd0);
        send_column(10'd0, 1'b0);
        send_column(10'd512, 1'b0);
        wait_idle();

        // Random phases: a random subset of registers rewritten each time, then a run
        // of columns. One phase holds the receiver off while columns keep coming.
        for (int phase = 0; phase < 24; phase++)
        begin
            for (int r = 0; r < 6; r++)
            begin
                idx = rcd_reg_t'(r);
                if ($urandom_range(0, 2) != 0)
                    write_reg(idx, (r < 2) ? pick_pos() : pick_dir());
            end
            if (phase == 3)
            begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (200) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 78; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    col = $urandom_range(0, 1023);
                else
                    col = $urandom_range(0, 639);
                send_column(col, (phase % 4) == 1);
            end
            wait_idle();
            phases_run++;
        end

        $display("Ran %0d columns over %0d register settings; %0d results checked,",
                 columns_sent, phases_run + 3, rays_checked);
        $display("%0d of them with an infinite delta on some axis.", inf_seen);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
